[rtl/core/sctl_pkg.sv]
// shared types and constants for the sorted code table lookup
`default_nettype none

package sctl_pkg;

  // field widths fixed by the interface
  localparam int DATA_W  = 16;
  localparam int ENTRY_W = 2 * DATA_W;
  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;
  localparam int APB_W   = 32;

  // register map: entry_count is register 0
  localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // bisection sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_CMP  = 3'b100
  } sctl_state_t;

endpackage

`default_nettype wire

[rtl/core/sctl_table.sv]
// code and info table: one write port, one registered read port
`default_nettype none

module sctl_table import sctl_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // write port, code in the upper half
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/sctl_search.sv]
// bisection sequencer: each table probe is a read state followed by a compare state
`default_nettype none

module sctl_search import sctl_pkg::*; #(
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     lookup_go,
  input  wire logic        [CW-1:0]     count,
  input  wire logic signed [DATA_W-1:0] key,
  output logic                          busy,
  output logic                          rd_en,
  output logic             [AW-1:0]     rd_addr,
  input  wire logic        [ENTRY_W-1:0] rd_data,
  output logic                          out_valid,
  output logic signed      [DATA_W-1:0] out_info
);

  sctl_state_t             state_r, state_nxt;
  logic        [CW-1:0]    low_r, low_nxt;
  logic        [CW-1:0]    high_r, high_nxt;
  logic        [AW-1:0]    mid_r, mid_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_info_r, out_info_nxt;

  logic        [CW-1:0]    mid_ext;
  logic        [CW:0]      mid_sum;
  logic signed [DATA_W-1:0] probe_code;
  logic signed [DATA_W-1:0] probe_info;

  assign mid_ext    = CW'(mid_r);
  assign probe_code = signed'(rd_data[ENTRY_W-1:DATA_W]);
  assign probe_info = signed'(rd_data[DATA_W-1:0]);
  assign mid_sum    = {1'b0, low_nxt} + {1'b0, high_nxt};

  // next state and search bounds
  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_info_nxt  = out_info_r;
    unique case (state_r)
      ST_IDLE: begin
        if (lookup_go) begin
          key_nxt  = key;
          low_nxt  = '0;
          high_nxt = count;
          if (count == '0) begin
            // empty table hands the key straight back
            out_valid_nxt = 1'b1;
            out_info_nxt  = key;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (mid_ext > low_r) begin
          if (probe_code > key_r) begin
            high_nxt = mid_ext;
          end else begin
            low_nxt = mid_ext;
          end
          state_nxt = ST_READ;
        end else begin
          // last probe: exact match or zero
          out_valid_nxt = 1'b1;
          out_info_nxt  = (probe_code == key_r) ? probe_info : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // midpoint of the bounds that hold next cycle
  assign mid_nxt = AW'(mid_sum >> 1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    low_r      <= low_nxt;
    high_r     <= high_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    out_info_r <= out_info_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign rd_en     = (state_r == ST_READ);
  assign rd_addr   = mid_r;
  assign out_valid = out_valid_r;
  assign out_info  = out_info_r;

  // a compare always follows its read
  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ($past(state_r) == ST_READ))
    else $error("compare without a preceding table read");

  // the probe stays inside the half-open interval [low, high)
  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ((mid_ext >= low_r) && (mid_ext < high_r)))
    else $error("probe address outside search bounds");

  // the final probe yields a result beat
  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CMP) && (mid_ext == low_r)) |=> out_valid_r)
    else $error("final probe gave no result beat");

  // a result never comes out of the middle of a search
  a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result beat while search still running");

endmodule

`default_nettype wire

[rtl/core/sorted_code_table_lookup.sv]
// top level: configuration register, load path and lookup sequencer
//
//   channel  direction  handshake              payload
//   config   in/out     psel penable pwrite    paddr pwdata prdata
//   input    in         start, busy            in_kind in_entry_index in_entry_code
//                                              in_entry_info in_lookup_code
//   result   out        out_valid              out_info_out
//
// a load is written at its accept edge and busy stays low, so items may follow at once
// a lookup makes between floor(log2(n))+1 and ceil(log2(n))+1 table probes for
// n = min(entry_count, TABLE_DEPTH), each a memory read state, then a compare state;
// busy stays high through every probe and the result beat comes out as busy drops
// an entry count of zero gives its result beat the cycle after accept, busy stays low
// rst_n is synchronous; the table holds no reset value and needs no clearing pass
// the result beat lasts one cycle and cannot be held off
`default_nettype none

module sorted_code_table_lookup import sctl_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic        [1:0]        paddr,
  input  wire logic        [APB_W-1:0]  pwdata,
  output logic             [APB_W-1:0]  prdata,
  output logic                          pready,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_kind,
  input  wire logic        [INDEX_W-1:0] in_entry_index,
  input  wire logic signed [DATA_W-1:0] in_entry_code,
  input  wire logic signed [DATA_W-1:0] in_entry_info,
  input  wire logic signed [DATA_W-1:0] in_lookup_code,
  output logic                          out_valid,
  output logic signed      [DATA_W-1:0] out_info_out
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

  logic [COUNT_W-1:0] entry_count_r;
  logic [CW-1:0]      search_count;
  logic [IW-1:0]      index_ext;
  logic               accept;
  logic               load_wr;
  logic               lookup_go;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // configuration register, written at the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_ENTRY_COUNT)) begin
      entry_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ENTRY_COUNT) ? APB_W'(entry_count_r) : '0;

  // count saturates at the table depth
  assign search_count = (32'(entry_count_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                           : CW'(entry_count_r);

  // input beat decode; busy interlocks table writes against a running search
  assign accept    = start && !busy;
  assign index_ext = IW'(in_entry_index);
  assign load_wr   = accept && (in_kind == KIND_LOAD) && (32'(in_entry_index) < TABLE_DEPTH);
  assign lookup_go = accept && (in_kind == KIND_LOOKUP);

  sctl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (index_ext[AW-1:0]),
    .wr_data ({in_entry_code, in_entry_info}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sctl_search #(
    .AW (AW),
    .CW (CW)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_go (lookup_go),
    .count     (search_count),
    .key       (in_lookup_code),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_info  (out_info_out)
  );

endmodule

`default_nettype wire
